// ===== design/rgba2icon_pkg.sv =====
// ============================================================================
// rgba2icon_pkg
// Shared types and constants for the RGBA to icon pixel and mask converter
// ============================================================================
package rgba2icon_pkg;

    localparam int MAX_DIMENSION  = 4096;
    localparam int MASK_WORD_BITS = 32;

    localparam int COMP_W    = 8;
    localparam int POS_W     = $clog2(MAX_DIMENSION);
    localparam int DIM_W     = POS_W + 1;
    localparam int BIT_IDX_W = $clog2(MASK_WORD_BITS);
    localparam int COLOUR_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 13;

    localparam int IN_DATA_W  = 4 * COMP_W;
    localparam int OUT_DATA_W = COLOUR_W + COMP_W + MASK_WORD_BITS + 2 * POS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ALPHA    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_FORMAT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

    localparam logic [COMP_W-1:0] ALPHA_THRESHOLD = 8'h80;
    localparam logic [COMP_W-1:0] ALPHA_OPAQUE    = 8'hFF;

    typedef enum logic [1:0] {
        COLOUR_NONE   = 2'd0,
        COLOUR_RGB565 = 2'd1,
        COLOUR_BGR888 = 2'd2,
        COLOUR_BGRA   = 2'd3
    } t_colour_fmt;

    typedef enum logic [1:0] {
        MASK_NONE    = 2'd0,
        MASK_ONE_BIT = 2'd1,
        MASK_ALPHA   = 2'd2
    } t_mask_fmt;

    // last index of a dimension register, with 0 read as 1 and oversize clamped
    function automatic logic [POS_W-1:0] last_index(input logic [DIM_W-1:0] dim);
        logic [POS_W-1:0] res;
        if (dim == '0) begin
            res = '0;
        end else if (dim > DIM_W'(MAX_DIMENSION)) begin
            res = POS_W'(MAX_DIMENSION - 1);
        end else begin
            res = POS_W'(dim - DIM_W'(1));
        end
        return res;
    endfunction

endpackage

// ===== design/rgba_to_icon_pixel_and_mask.sv =====
// ============================================================================
// rgba_to_icon_pixel_and_mask
// Converts RGBA8888 pixels to a colour word, a mask value and a position
// ============================================================================
// Takes one RGBA pixel per clock in raster order while the result side does
// not stall, and returns one result beat per pixel from the result register.
// The pixel goes into an input register, the colour packing, mask bit and
// position logic sits between it and the result register, and the column,
// row and one-bit mask word advance as the pixel leaves the input register.
// The user must write configuration through the plain write port only while
// no pixel is in flight; the block itself does not enforce it. Position
// counters are not cleared by writes.
module rgba_to_icon_pixel_and_mask (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rgba2icon_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rgba2icon_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // red, green, blue, alpha
    input  logic [rgba2icon_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // colour_value, mask_byte, mask_word, column, row
    output logic [rgba2icon_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // mask_word_ready
    output logic                                   o_m_tuser,
    // last_pixel
    output logic                                   o_m_tlast
);

    localparam int CW = rgba2icon_pkg::COMP_W;
    localparam int PW = rgba2icon_pkg::POS_W;
    localparam int MW = rgba2icon_pkg::MASK_WORD_BITS;

    rgba2icon_pkg::t_colour_fmt          r_colour_fmt;
    logic                                r_keep_alpha;
    rgba2icon_pkg::t_mask_fmt            r_mask_fmt;
    logic [rgba2icon_pkg::DIM_W-1:0]     r_width;
    logic [rgba2icon_pkg::DIM_W-1:0]     r_height;

    logic                                r_in_valid;
    logic [CW-1:0]                       r_red, r_green, r_blue, r_alpha;

    logic [PW-1:0]                       r_col, r_row;
    logic [MW-1:0]                       r_acc;

    logic                                r_out_valid;
    logic [rgba2icon_pkg::COLOUR_W-1:0]  r_colour;
    logic [CW-1:0]                       r_mask_byte;
    logic [MW-1:0]                       r_mask_word;
    logic                                r_word_ready;
    logic [PW-1:0]                       r_out_col, r_out_row;
    logic                                r_last;

    logic                                adv;
    logic                                row_end, last_row;
    logic [rgba2icon_pkg::BIT_IDX_W-1:0] bit_idx;
    logic [MW-1:0]                       acc_or;
    logic                                word_end;
    logic [rgba2icon_pkg::COLOUR_W-1:0]  n_colour;
    logic [CW-1:0]                       n_mask_byte;
    logic [MW-1:0]                       n_mask_word;
    logic                                n_word_ready;
    logic [MW-1:0]                       n_acc;
    logic [PW-1:0]                       n_col, n_row;
    logic [CW-1:0]                       top_byte;

    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour_fmt <= rgba2icon_pkg::COLOUR_RGB565;
            r_keep_alpha <= 1'b0;
            r_mask_fmt   <= rgba2icon_pkg::MASK_ONE_BIT;
            r_width      <= rgba2icon_pkg::DIM_W'(1);
            r_height     <= rgba2icon_pkg::DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rgba2icon_pkg::CFG_COLOUR_FORMAT: begin
                    r_colour_fmt <= rgba2icon_pkg::t_colour_fmt'(i_cfg_data[1:0]);
                end
                rgba2icon_pkg::CFG_KEEP_ALPHA: begin
                    r_keep_alpha <= i_cfg_data[0];
                end
                rgba2icon_pkg::CFG_MASK_FORMAT: begin
                    r_mask_fmt <= rgba2icon_pkg::t_mask_fmt'(i_cfg_data[1:0]);
                end
                rgba2icon_pkg::CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data;
                end
                rgba2icon_pkg::CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_red   <= i_s_tdata[CW-1:0];
            r_green <= i_s_tdata[2*CW-1:CW];
            r_blue  <= i_s_tdata[3*CW-1:2*CW];
            r_alpha <= i_s_tdata[4*CW-1:3*CW];
        end
    end

    // per-pixel logic
    always_comb begin
        row_end  = r_col >= rgba2icon_pkg::last_index(r_width);
        last_row = r_row >= rgba2icon_pkg::last_index(r_height);
        bit_idx  = r_col[rgba2icon_pkg::BIT_IDX_W-1:0];
        word_end = (&bit_idx) || row_end;
        acc_or   = r_acc;
        if (r_alpha >= rgba2icon_pkg::ALPHA_THRESHOLD) begin
            acc_or[bit_idx] = 1'b1;
        end

        top_byte = r_keep_alpha ? r_alpha : rgba2icon_pkg::ALPHA_OPAQUE;
        case (r_colour_fmt)
            rgba2icon_pkg::COLOUR_RGB565: begin
                n_colour = {16'd0, r_red[7:3], r_green[7:2], r_blue[7:3]};
            end
            rgba2icon_pkg::COLOUR_BGR888: begin
                n_colour = {8'd0, r_red, r_green, r_blue};
            end
            rgba2icon_pkg::COLOUR_BGRA: begin
                n_colour = {top_byte, r_red, r_green, r_blue};
            end
            default: begin
                n_colour = '0;
            end
        endcase

        n_mask_byte  = '0;
        n_mask_word  = '0;
        n_word_ready = 1'b0;
        n_acc        = r_acc;
        case (r_mask_fmt)
            rgba2icon_pkg::MASK_ONE_BIT: begin
                if (word_end) begin
                    n_mask_word  = acc_or;
                    n_word_ready = 1'b1;
                    n_acc        = '0;
                end else begin
                    n_acc = acc_or;
                end
            end
            rgba2icon_pkg::MASK_ALPHA: begin
                n_mask_byte = r_alpha;
            end
            default: begin
            end
        endcase

        if (row_end) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + PW'(1);
        end else begin
            n_col = r_col + PW'(1);
            n_row = r_row;
        end
    end

    // position and mask word state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_acc <= '0;
        end else if (adv) begin
            r_col <= n_col;
            r_row <= n_row;
            r_acc <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_colour     <= n_colour;
            r_mask_byte  <= n_mask_byte;
            r_mask_word  <= n_mask_word;
            r_word_ready <= n_word_ready;
            r_out_col    <= r_col;
            r_out_row    <= r_row;
            r_last       <= row_end && last_row;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_row, r_out_col, r_mask_word, r_mask_byte, r_colour};
    assign o_m_tuser  = r_word_ready;
    assign o_m_tlast  = r_last;

    // checks
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_word_zero_unless_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (r_mask_word == '0))
        else $error("mask word set without ready");

    a_col_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !row_end) |=> (r_col == $past(r_col) + PW'(1)))
        else $error("column did not advance");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (o_m_tvalid && (r_out_col == $past(r_col))))
        else $error("result not loaded");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Stream-level check of the RGBA to icon pixel and mask converter
// ============================================================================
// Pixels go in on the slave stream. Each accepted pixel is run through a
// local model of the converter: colour packing, the alpha mask, the one-bit
// mask word and the raster position. The result is queued and compared field
// by field with the next result beat. A short directed table comes first:
// reset values, the format extremes, the alpha threshold, clamped sizes and a
// shrink below the current position. Random phases follow, with new register
// settings between them. Both stream sides idle at random, and once the
// result side is held off long enough for the input to back up.
module testbench;

    localparam int MAX_DIMENSION  = rgba2icon_pkg::MAX_DIMENSION;
    localparam int MASK_WORD_BITS = rgba2icon_pkg::MASK_WORD_BITS;
    localparam int COMP_W         = rgba2icon_pkg::COMP_W;
    localparam int POS_W          = rgba2icon_pkg::POS_W;
    localparam int COLOUR_W       = rgba2icon_pkg::COLOUR_W;
    localparam int CFG_IDX_W      = rgba2icon_pkg::CFG_IDX_W;
    localparam int CFG_W          = rgba2icon_pkg::CFG_W;
    localparam int IN_DATA_W      = rgba2icon_pkg::IN_DATA_W;
    localparam int OUT_DATA_W     = rgba2icon_pkg::OUT_DATA_W;

    typedef struct packed {
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
        logic [MASK_WORD_BITS-1:0] mask_word;
        logic [COMP_W-1:0]         mask_byte;
        logic [COLOUR_W-1:0]       colour;
    } t_beat_data;

    typedef struct {
        t_beat_data data;
        logic       word_ready;
        logic       last;
    } t_icon_beat;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        logic [31:0]          px;
        bit                   typed;
        t_icon_beat           want;
    } t_plan_row;

    localparam int TOTAL_PIXELS = 1700;
    localparam int HOLD_CYCLES  = 80;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    // model copy of the registers and the position / mask state
    rgba2icon_pkg::t_colour_fmt fmt_colour;
    logic              keep_alpha;
    logic [1:0]        fmt_mask;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [POS_W-1:0]  col_cnt;
    logic [POS_W-1:0]  row_cnt;
    logic [31:0]       mask_acc;

    t_icon_beat icon_beats_due[$];
    t_plan_row  plan[$];
    int         errors;
    int         sent;
    bit         calm;
    bit         hold_request;
    bit         hold_done;
    int         hold_left;

    rgba_to_icon_pixel_and_mask u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // red, green, blue, alpha
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // colour_value, mask_byte, mask_word, column, row
        .o_m_tuser   (o_m_tuser),   // mask_word_ready
        .o_m_tlast   (o_m_tlast)    // last_pixel
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_row(input t_plan_row plan_row);
        plan.insert(plan.size(), plan_row);
    endfunction

    function automatic void add_due(input t_icon_beat due_beat);
        icon_beats_due.insert(icon_beats_due.size(), due_beat);
    endfunction

    function automatic int unsigned dim_clamp(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > CFG_W'(MAX_DIMENSION)) begin
            return MAX_DIMENSION;
        end
        return 32'(v);
    endfunction

    function automatic t_icon_beat convert_pixel(input logic [31:0] px);
        t_icon_beat  b;
        logic [7:0]  r, g, bl, a;
        int unsigned w, h;
        bit          row_end, last_row;
        logic [4:0]  bit_idx;
        r = px[7:0];
        g = px[15:8];
        bl = px[23:16];
        a = px[31:24];
        w = dim_clamp(width_reg);
        h = dim_clamp(height_reg);
        row_end = col_cnt >= w - 1;
        last_row = row_cnt >= h - 1;
        b = '{default: '0};
        case (fmt_colour)
            rgba2icon_pkg::COLOUR_RGB565: b.data.colour = {16'h0, r[7:3], g[7:2], bl[7:3]};
            rgba2icon_pkg::COLOUR_BGR888: b.data.colour = {8'h0, r, g, bl};
            rgba2icon_pkg::COLOUR_BGRA:
                b.data.colour = {keep_alpha ? a : rgba2icon_pkg::ALPHA_OPAQUE, r, g, bl};
            default:       b.data.colour = '0;
        endcase
        if (fmt_mask == rgba2icon_pkg::MASK_ONE_BIT) begin
            bit_idx = col_cnt[4:0];
            if (a >= rgba2icon_pkg::ALPHA_THRESHOLD) begin
                mask_acc[bit_idx] = 1'b1;
            end
            if (bit_idx == 5'(MASK_WORD_BITS - 1) || row_end) begin
                b.data.mask_word = mask_acc;
                b.word_ready = 1'b1;
                mask_acc = '0;
            end
        end else if (fmt_mask == rgba2icon_pkg::MASK_ALPHA) begin
            b.data.mask_byte = a;
        end
        b.data.col = col_cnt;
        b.data.row = row_cnt;
        b.last = row_end && last_row;
        if (row_end) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_beat(input t_icon_beat got);
        t_icon_beat want;
        if (icon_beats_due.size() == 0) begin
            report_mismatch("beat with none pending", got.data.colour, '0);
            return;
        end
        want = icon_beats_due.pop_front();
        if (got.data.colour !== want.data.colour)
            report_mismatch("colour_value", got.data.colour, want.data.colour);
        if (got.data.mask_byte !== want.data.mask_byte)
            report_mismatch("mask_byte", 32'(got.data.mask_byte), 32'(want.data.mask_byte));
        if (got.data.mask_word !== want.data.mask_word)
            report_mismatch("mask_word", got.data.mask_word, want.data.mask_word);
        if (got.word_ready !== want.word_ready)
            report_mismatch("mask_word_ready", 32'(got.word_ready), 32'(want.word_ready));
        if (got.data.col !== want.data.col)
            report_mismatch("column", 32'(got.data.col), 32'(want.data.col));
        if (got.data.row !== want.data.row)
            report_mismatch("row", 32'(got.data.row), 32'(want.data.row));
        if (got.last !== want.last)
            report_mismatch("last_pixel", 32'(got.last), 32'(want.last));
    endtask

    // result side: check on handshake, then pick tready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            check_beat('{t_beat_data'(o_m_tdata), o_m_tuser, o_m_tlast});
        end
        if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            rgba2icon_pkg::CFG_COLOUR_FORMAT:
                fmt_colour = rgba2icon_pkg::t_colour_fmt'(val[1:0]);
            rgba2icon_pkg::CFG_KEEP_ALPHA:    keep_alpha = val[0];
            rgba2icon_pkg::CFG_MASK_FORMAT:   fmt_mask = val[1:0];
            rgba2icon_pkg::CFG_IMAGE_WIDTH:   width_reg = val;
            rgba2icon_pkg::CFG_IMAGE_HEIGHT:  height_reg = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (icon_beats_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [31:0] px, input bit typed, input t_icon_beat want);
        t_icon_beat predicted;
        i_cfg_we <= 1'b0;
        if (!calm && $urandom_range(0, 99) < 9) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= px;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = convert_pixel(px);
        add_due(typed ? want : predicted);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim(input bit is_height);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'(MAX_DIMENSION);
            2: return CFG_W'($urandom_range(MAX_DIMENSION + 1, 8191));
            3: return is_height ? CFG_W'($urandom_range(5, 12))
                                : CFG_W'($urandom_range(31, 33) + 32 * $urandom_range(0, 1));
            default: return is_height ? CFG_W'($urandom_range(1, 4))
                                      : CFG_W'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [31:0] random_pixel();
        logic [31:0] px;
        px = $urandom();
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0: px[31:24] = rgba2icon_pkg::ALPHA_THRESHOLD;
                1: px[31:24] = rgba2icon_pkg::ALPHA_THRESHOLD - 1'b1;
                2: px[31:24] = '0;
                default: px[31:24] = rgba2icon_pkg::ALPHA_OPAQUE;
            endcase
        end
        return px;
    endfunction

    initial begin
        // directed table
        add_row('{0, '0, '0, 32'hFFFFFFFF, 1,
                  '{'{12'd0, 12'd0, 32'h1, 8'h00, 32'h0000FFFF}, 1'b1, 1'b1}});
        add_row('{0, '0, '0, 32'h7F000000, 1,
                  '{'{12'd0, 12'd0, 32'h0, 8'h00, 32'h00000000}, 1'b1, 1'b1}});
        add_row('{0, '0, '0, 32'h80080408, 1,
                  '{'{12'd0, 12'd0, 32'h1, 8'h00, 32'h00000821}, 1'b1, 1'b1}});
        add_row('{1, rgba2icon_pkg::CFG_COLOUR_FORMAT,
                  CFG_W'(rgba2icon_pkg::COLOUR_BGR888), '0, 0, '{default: '0}});
        add_row('{1, rgba2icon_pkg::CFG_MASK_FORMAT,
                  CFG_W'(rgba2icon_pkg::MASK_ALPHA), '0, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'h78563412, 1,
                  '{'{12'd0, 12'd0, 32'h0, 8'h78, 32'h00123456}, 1'b0, 1'b1}});
        add_row('{1, rgba2icon_pkg::CFG_COLOUR_FORMAT,
                  CFG_W'(rgba2icon_pkg::COLOUR_BGRA), '0, 0, '{default: '0}});
        add_row('{1, rgba2icon_pkg::CFG_KEEP_ALPHA, CFG_W'(0), '0, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'h78563412, 1,
                  '{'{12'd0, 12'd0, 32'h0, 8'h78, 32'hFF123456}, 1'b0, 1'b1}});
        add_row('{1, rgba2icon_pkg::CFG_KEEP_ALPHA, CFG_W'(1), '0, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'h00FFFFFF, 1,
                  '{'{12'd0, 12'd0, 32'h0, 8'h00, 32'h00FFFFFF}, 1'b0, 1'b1}});
        // no colour, reserved mask format
        add_row('{1, rgba2icon_pkg::CFG_COLOUR_FORMAT,
                  CFG_W'(rgba2icon_pkg::COLOUR_NONE), '0, 0, '{default: '0}});
        add_row('{1, rgba2icon_pkg::CFG_MASK_FORMAT, CFG_W'(3), '0, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'hFFFFFFFF, 1,
                  '{'{12'd0, 12'd0, 32'h0, 8'h00, 32'h0}, 1'b0, 1'b1}});
        // zero sizes act as one
        add_row('{1, rgba2icon_pkg::CFG_IMAGE_WIDTH, '0, '0, 0, '{default: '0}});
        add_row('{1, rgba2icon_pkg::CFG_IMAGE_HEIGHT, '0, '0, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'h80FFFFFF, 1,
                  '{'{12'd0, 12'd0, 32'h0, 8'h00, 32'h0}, 1'b0, 1'b1}});
        // small image with one-bit mask
        add_row('{1, rgba2icon_pkg::CFG_COLOUR_FORMAT,
                  CFG_W'(rgba2icon_pkg::COLOUR_RGB565), '0, 0, '{default: '0}});
        add_row('{1, rgba2icon_pkg::CFG_MASK_FORMAT,
                  CFG_W'(rgba2icon_pkg::MASK_ONE_BIT), '0, 0, '{default: '0}});
        add_row('{1, rgba2icon_pkg::CFG_IMAGE_WIDTH, CFG_W'(3), '0, 0, '{default: '0}});
        add_row('{1, rgba2icon_pkg::CFG_IMAGE_HEIGHT, CFG_W'(2), '0, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'hFF102030, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'h7FA0B0C0, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'h80FFFFFF, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'h00000000, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'hC0123456, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'h81ABCDEF, 0, '{default: '0}});
        // oversize dimensions clamp
        add_row('{1, rgba2icon_pkg::CFG_IMAGE_WIDTH, CFG_W'(8191), '0, 0, '{default: '0}});
        add_row('{1, rgba2icon_pkg::CFG_IMAGE_HEIGHT, CFG_W'(5000), '0, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'hFF000000, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'hFF555555, 0, '{default: '0}});
        // shrink below the current column
        add_row('{1, rgba2icon_pkg::CFG_IMAGE_WIDTH, CFG_W'(1), '0, 0, '{default: '0}});
        add_row('{1, rgba2icon_pkg::CFG_IMAGE_HEIGHT, CFG_W'(1), '0, 0, '{default: '0}});
        add_row('{1, rgba2icon_pkg::CFG_MASK_FORMAT,
                  CFG_W'(rgba2icon_pkg::MASK_NONE), '0, 0, '{default: '0}});
        add_row('{0, '0, '0, 32'hFFFFFFFF, 1,
                  '{'{12'd0, 12'd2, 32'h0, 8'h00, 32'h0000FFFF}, 1'b0, 1'b1}});
        add_row('{0, '0, '0, 32'h01020304, 0, '{default: '0}});

        // reset values
        fmt_colour = rgba2icon_pkg::COLOUR_RGB565;
        keep_alpha = 1'b0;
        fmt_mask = rgba2icon_pkg::MASK_ONE_BIT;
        width_reg = CFG_W'(1);
        height_reg = CFG_W'(1);
        col_cnt = '0;
        row_cnt = '0;
        mask_acc = '0;
        sent = 0;
        calm = 1'b0;
        hold_request = 1'b0;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_pixel(plan[i].px, plan[i].typed, plan[i].want);
            end
        end

        // random phases, new settings between them
        for (int phase = 0; sent < TOTAL_PIXELS; phase++) begin
            int n;
            i_s_tvalid <= 1'b0;
            wait_drained();
            calm = (phase >= 8 && phase < 14);
            if ($urandom_range(0, 9) != 0) begin
                write_reg(rgba2icon_pkg::CFG_COLOUR_FORMAT, CFG_W'($urandom_range(0, 3)));
                write_reg(rgba2icon_pkg::CFG_KEEP_ALPHA, CFG_W'($urandom_range(0, 1)));
                write_reg(rgba2icon_pkg::CFG_MASK_FORMAT, CFG_W'($urandom_range(0, 3)));
                write_reg(rgba2icon_pkg::CFG_IMAGE_WIDTH, pick_dim(1'b0));
                write_reg(rgba2icon_pkg::CFG_IMAGE_HEIGHT, pick_dim(1'b1));
            end
            n = $urandom_range(10, 80);
            if (phase == 3) begin
                hold_request = 1'b1;
                n = 60;
            end
            repeat (n) begin
                send_pixel(random_pixel(), 1'b0, '{default: '0});
                sent++;
            end
        end
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== rgba_to_icon_pixel_and_mask.f =====
design/rgba2icon_pkg.sv
design/rgba_to_icon_pixel_and_mask.sv
bench/testbench.sv
